// ===== hdl/sitda_pkg.sv =====
// Shared types, character constants and digit-count helper for the integer-to-text block.
package sitda_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam int         DIGIT_BITS = 4;

  typedef struct packed {
    logic load;
    logic conv;
    logic shift_digit;
    logic sel_sign;
  } sitda_cmd_t;

  typedef struct packed {
    logic bits_done;
    logic top_zero;
    logic last_digit;
    logic negative;
  } sitda_stat_t;

  function automatic int dec_digits(input int value_bits);
    logic [63:0] v;
    int          n;
    begin
      v = 64'd1 << (value_bits - 1);
      n = 0;
      do begin
        n = n + 1;
        v = v / 64'd10;
      end while (v != 64'd0);
      return n;
    end
  endfunction

endpackage

// ===== hdl/sitda_dpath.sv =====
// Datapath: magnitude shifter, shift-and-add-3 decimal register and character select.
module sitda_dpath
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [VALUE_BITS-1:0] in_value,
  input  sitda_cmd_t            cmd,
  output sitda_stat_t           stat,
  output logic [7:0]            out_char_code,
  output logic                  out_last_char
);

  localparam int NDIG  = dec_digits(VALUE_BITS);
  localparam int BCD_W = NDIG * DIGIT_BITS;
  localparam int BW    = $clog2(VALUE_BITS + 1);
  localparam int DW    = $clog2(NDIG + 1);

  logic [VALUE_BITS-1:0] mag_r, mag_nxt, mag_in;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt, bcd_adj;
  logic                  neg_r, neg_nxt;
  logic [BW-1:0]         bit_cnt_r, bit_cnt_nxt;
  logic [DW-1:0]         dig_cnt_r, dig_cnt_nxt;
  logic [DIGIT_BITS-1:0] top_digit;

  assign mag_in = in_value[VALUE_BITS-1]
                ? (~in_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : in_value;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
        bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_r[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_r[i*DIGIT_BITS +: DIGIT_BITS];
      end
    end
  end

  always_comb begin
    mag_nxt     = mag_r;
    bcd_nxt     = bcd_r;
    neg_nxt     = neg_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    if (cmd.load) begin
      mag_nxt     = mag_in;
      bcd_nxt     = '0;
      neg_nxt     = in_value[VALUE_BITS-1];
      bit_cnt_nxt = BW'(VALUE_BITS);
      dig_cnt_nxt = DW'(NDIG);
    end else if (cmd.conv) begin
      bcd_nxt     = {bcd_adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
      mag_nxt     = {mag_r[VALUE_BITS-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r - 1'b1;
    end else if (cmd.shift_digit) begin
      bcd_nxt     = bcd_r << DIGIT_BITS;
      dig_cnt_nxt = dig_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r <= '0;
      dig_cnt_r <= '0;
      neg_r     <= 1'b0;
    end else begin
      bit_cnt_r <= bit_cnt_nxt;
      dig_cnt_r <= dig_cnt_nxt;
      neg_r     <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_BITS];

  assign stat.bits_done  = (bit_cnt_r == BW'(1));
  assign stat.top_zero   = (top_digit == '0);
  assign stat.last_digit = (dig_cnt_r == DW'(1));
  assign stat.negative   = neg_r;

  assign out_char_code = cmd.sel_sign ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, top_digit});
  assign out_last_char = stat.last_digit & ~cmd.sel_sign;

endmodule

// ===== hdl/sitda_ctrl.sv =====
// Controller state machine sequencing load, conversion, zero skip and character output.
module sitda_ctrl
  import sitda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  sitda_stat_t stat,
  output sitda_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_SKIP  = 5'b00100,
    S_SIGN  = 5'b01000,
    S_DIGIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        if (stat.bits_done) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (stat.top_zero && !stat.last_digit) begin
          cmd.shift_digit = 1'b1;
        end else if (stat.negative) begin
          state_nxt = S_SIGN;
        end else begin
          state_nxt = S_DIGIT;
        end
      end
      S_SIGN: begin
        out_valid    = 1'b1;
        cmd.sel_sign = 1'b1;
        if (out_ready) begin
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.last_digit) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.shift_digit = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// Top level of the signed integer to decimal ASCII text converter.
// Each input transaction carries one two's complement value of VALUE_BITS bits; the block
// answers with its decimal text, one ASCII character per output transaction, most
// significant first, a leading '-' for negative values, no leading zeros, and
// out_last_char set on the final character. Values are converted one at a time by a
// bit-serial shift-and-add-3 converter: the value is accepted, converted one input bit at
// a time, its suppressed leading zeros are skipped one digit at a time, then the sign and
// digits are offered, each held while out_ready is low. The decimal register holds NDIG
// digits, the digit count of 2^(VALUE_BITS-1), and a new value is taken only when idle.
module signed_int_to_decimal_ascii
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_char_code,
  output logic                  out_last_char
);

  sitda_cmd_t  cmd;
  sitda_stat_t stat;

  sitda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sitda_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .stat          (stat),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

endmodule

// ===== hdl/sitda_checker.sv =====
// Port-level checker for the integer-to-text converter, bound to its top level.
module sitda_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char_code,
  input logic       out_last_char
);

  // Only one value is in flight, so no input transaction is taken while text is offered.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a character is offered");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code) && $stable(out_last_char))
    else $error("stalled character changed");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == 8'd45) ||
                  ((out_char_code >= 8'd48) && (out_char_code <= 8'd57)))
    else $error("character is neither a digit nor a minus sign");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char_code == 8'd45) |-> !out_last_char)
    else $error("minus sign flagged as last character");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("converter not busy after an input transaction");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_char_code (out_char_code),
  .out_last_char (out_last_char)
);
